/* sv/fbsm_pkg.sv */
// ----------------------------------------------------------------------------
// fbsm_pkg
// Shared types and codes of the frame buffer slot manager.
// ----------------------------------------------------------------------------
package fbsm_pkg;

    typedef logic [2:0] t_slot_st;

    localparam t_slot_st ST_FREE   = 3'd0;
    localparam t_slot_st ST_WRITE  = 3'd1;
    localparam t_slot_st ST_LEASED = 3'd2;
    localparam t_slot_st ST_WAIT   = 3'd3;
    localparam t_slot_st ST_DEAD   = 3'd4;

    typedef logic [3:0] t_op;

    localparam t_op OP_ACQUIRE = 4'd0;
    localparam t_op OP_QUERY   = 4'd1;
    localparam t_op OP_SEAL    = 4'd2;
    localparam t_op OP_FAIL    = 4'd3;
    localparam t_op OP_DROP    = 4'd4;
    localparam t_op OP_CANCEL  = 4'd5;
    localparam t_op OP_RETIRE  = 4'd6;
    localparam t_op OP_CLOSE   = 4'd7;
    localparam t_op OP_STOP    = 4'd8;

    typedef logic [1:0] t_status;

    localparam t_status STS_OK     = 2'd0;
    localparam t_status STS_BUSY   = 2'd1;
    localparam t_status STS_FAILED = 2'd2;
    localparam t_status STS_REJECT = 2'd3;

    localparam int IDX_W    = 3;
    localparam int OUT_GEN_W = 32;
    localparam int CFG_W    = 4;
    localparam int FENCE_W  = 8;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

endpackage

/* sv/fbsm_ctrl.sv */
// ----------------------------------------------------------------------------
// fbsm_ctrl
// Request sequencer: capture a transaction, then commit it into the output
// register once that register is free or being emptied.
// ----------------------------------------------------------------------------
module fbsm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output fbsm_pkg::t_cmd o_cmd
);
    import fbsm_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_valid, n_valid;
    logic w_room;

    assign w_room  = !r_valid || i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid && !i_ready;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_room) begin
                    o_cmd.commit = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

/* sv/fbsm_dp.sv */
// ----------------------------------------------------------------------------
// fbsm_dp
// Slot table, pool flags and result register. Evaluates one request per
// commit: fence resolution, lowest-free grant, checked slot transitions.
// ----------------------------------------------------------------------------
module fbsm_dp #(
    parameter int MAX_SLOT_COUNT = 8,
    parameter int GEN_BITS       = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fbsm_pkg::t_cmd                 i_cmd,
    input  logic [fbsm_pkg::CFG_W-1:0]     i_active_slots,
    input  fbsm_pkg::t_op                  i_op,
    input  logic [fbsm_pkg::IDX_W-1:0]     i_slot_index,
    input  logic [fbsm_pkg::OUT_GEN_W-1:0] i_req_generation,
    input  logic                           i_sync_valid,
    input  logic [fbsm_pkg::FENCE_W-1:0]   i_fence_ready_mask,
    input  logic [fbsm_pkg::FENCE_W-1:0]   i_fence_failed_mask,
    output fbsm_pkg::t_status              o_status,
    output logic [fbsm_pkg::IDX_W-1:0]     o_granted_slot,
    output logic [fbsm_pkg::OUT_GEN_W-1:0] o_granted_generation,
    output logic                           o_pool_is_failed,
    output logic                           o_pool_is_open
);
    import fbsm_pkg::*;

    localparam int N     = MAX_SLOT_COUNT;
    localparam int CMP_W = (GEN_BITS > OUT_GEN_W) ? GEN_BITS : OUT_GEN_W;

    t_op                    r_op;
    logic [IDX_W-1:0]       r_idx;
    logic [OUT_GEN_W-1:0]   r_req_gen;
    logic                   r_sync;
    logic [FENCE_W-1:0]     r_rdy_mask;
    logic [FENCE_W-1:0]     r_fail_mask;

    t_slot_st               r_slot_st [N];
    t_slot_st               n_slot_st [N];
    logic [GEN_BITS-1:0]    r_slot_gen [N];
    logic [GEN_BITS-1:0]    n_slot_gen [N];
    logic                   r_open, n_open;
    logic                   r_closed, n_closed;
    logic                   r_failed, n_failed;

    t_status                r_o_status, n_o_status;
    logic [IDX_W-1:0]       r_o_slot, n_o_slot;
    logic [OUT_GEN_W-1:0]   r_o_gen, n_o_gen;

    logic [N-1:0]           w_in_use, w_sel, w_frdy, w_ffail, w_wf, w_first_fail, w_below;
    logic [N-1:0]           w_free, w_live, w_grant;
    t_slot_st               w_res [N];
    t_slot_st               w_sel_st;
    logic [GEN_BITS-1:0]    w_sel_gen, w_grant_gen;
    logic [IDX_W-1:0]       w_gslot;

    // per-slot decode and fence resolution
    always_comb begin
        w_sel_st    = ST_FREE;
        w_sel_gen   = '0;
        for (int i = 0; i < N; i++) begin
            w_in_use[i] = int'(i_active_slots) > i;
            w_sel[i]    = w_in_use[i] && (int'(r_idx) == i);
            w_ffail[i]  = (i < FENCE_W) && r_fail_mask[3'(i)];
            w_frdy[i]   = (i < FENCE_W) && r_rdy_mask[3'(i)] && !w_ffail[i];
            w_wf[i]     = w_in_use[i] && (r_slot_st[i] == ST_WAIT) && w_ffail[i];
            if (w_sel[i]) begin
                w_sel_st  = r_slot_st[i];
                w_sel_gen = r_slot_gen[i];
            end
        end
        w_first_fail = w_wf & (~w_wf + N'(1));
        w_below      = w_first_fail - N'(1);
        for (int i = 0; i < N; i++) begin
            w_res[i] = r_slot_st[i];
            if (w_in_use[i] && (r_slot_st[i] == ST_WAIT) && w_below[i] && w_frdy[i]) begin
                w_res[i] = ST_FREE;
            end
            if (w_first_fail[i]) begin
                w_res[i] = ST_DEAD;
            end
            w_free[i] = w_in_use[i] && (w_res[i] == ST_FREE);
            w_live[i] = w_in_use[i] && (w_res[i] != ST_DEAD);
        end
        w_grant     = w_free & (~w_free + N'(1));
        w_grant_gen = '0;
        w_gslot     = '0;
        for (int i = 0; i < N; i++) begin
            if (w_grant[i]) begin
                w_grant_gen = r_slot_gen[i];
                w_gslot     = IDX_W'(i);
            end
        end
    end

    always_comb begin
        logic                match;
        logic                writing;
        logic                usable;
        logic                set_sel;
        t_slot_st            new_st;
        logic [GEN_BITS-1:0] new_gen;

        match   = (|w_sel) && (CMP_W'(w_sel_gen) == CMP_W'(r_req_gen));
        writing = match && (w_sel_st == ST_WRITE);
        usable  = r_open && !r_failed;
        set_sel = 1'b0;
        new_st  = ST_DEAD;
        new_gen = w_grant_gen + GEN_BITS'(1);

        n_slot_st  = r_slot_st;
        n_slot_gen = r_slot_gen;
        n_open     = r_open;
        n_closed   = r_closed;
        n_failed   = r_failed;
        n_o_status = STS_REJECT;
        n_o_slot   = '0;
        n_o_gen    = '0;

        unique case (r_op)
            OP_ACQUIRE: begin
                if (!usable) begin
                    n_o_status = STS_FAILED;
                end else begin
                    n_slot_st = w_res;
                    if (|w_wf) begin
                        n_failed   = 1'b1;
                        n_o_status = STS_FAILED;
                    end else if (|w_grant) begin
                        for (int i = 0; i < N; i++) begin
                            if (w_grant[i]) begin
                                n_slot_st[i]  = ST_WRITE;
                                n_slot_gen[i] = new_gen;
                            end
                        end
                        n_o_status = STS_OK;
                        n_o_slot   = w_gslot;
                        n_o_gen    = OUT_GEN_W'(new_gen);
                    end else begin
                        n_o_status = (|w_live) ? STS_BUSY : STS_FAILED;
                    end
                end
            end
            OP_QUERY: begin
                if (usable && writing) begin
                    n_o_status = STS_OK;
                end
            end
            OP_SEAL: begin
                if (usable && writing && r_sync) begin
                    set_sel    = 1'b1;
                    new_st     = ST_LEASED;
                    n_o_status = STS_OK;
                end
            end
            OP_FAIL: begin
                if (writing) begin
                    set_sel    = 1'b1;
                    new_st     = r_open ? ST_WAIT : ST_DEAD;
                    n_o_status = STS_OK;
                end
            end
            OP_DROP: begin
                if (match && (w_sel_st == ST_WRITE)) begin
                    set_sel    = 1'b1;
                    new_st     = ST_DEAD;
                    n_o_status = STS_OK;
                end else if (match && (w_sel_st == ST_LEASED)) begin
                    set_sel    = 1'b1;
                    n_o_status = STS_OK;
                    if (!r_open) begin
                        new_st = ST_DEAD;
                    end else if (r_fail_mask[r_idx]) begin
                        new_st   = ST_DEAD;
                        n_failed = 1'b1;
                    end else if (r_rdy_mask[r_idx]) begin
                        new_st = ST_FREE;
                    end else begin
                        new_st = ST_WAIT;
                    end
                end
            end
            OP_CANCEL: begin
                if (writing) begin
                    set_sel    = 1'b1;
                    new_st     = r_open ? ST_FREE : ST_DEAD;
                    n_o_status = STS_OK;
                end
            end
            OP_RETIRE: begin
                if (writing) begin
                    set_sel    = 1'b1;
                    new_st     = ST_DEAD;
                    n_o_status = STS_OK;
                end
            end
            OP_CLOSE: begin
                if (!r_closed) begin
                    n_open   = 1'b0;
                    n_closed = 1'b1;
                    for (int i = 0; i < N; i++) begin
                        if (w_in_use[i] && (r_slot_st[i] != ST_LEASED)
                                && (r_slot_st[i] != ST_WRITE)) begin
                            n_slot_st[i] = ST_DEAD;
                        end
                    end
                    n_o_status = STS_OK;
                end
            end
            OP_STOP: begin
                n_open     = 1'b0;
                n_o_status = STS_OK;
            end
            default: n_o_status = STS_REJECT;
        endcase

        if (set_sel) begin
            for (int i = 0; i < N; i++) begin
                if (w_sel[i]) begin
                    n_slot_st[i] = new_st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_idx       <= i_slot_index;
            r_req_gen   <= i_req_generation;
            r_sync      <= i_sync_valid;
            r_rdy_mask  <= i_fence_ready_mask;
            r_fail_mask <= i_fence_failed_mask;
        end
        if (i_cmd.commit) begin
            r_o_status <= n_o_status;
            r_o_slot   <= n_o_slot;
            r_o_gen    <= n_o_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_slot_st[i]  <= ST_FREE;
                r_slot_gen[i] <= '0;
            end
            r_open   <= 1'b1;
            r_closed <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_cmd.commit) begin
            r_slot_st  <= n_slot_st;
            r_slot_gen <= n_slot_gen;
            r_open     <= n_open;
            r_closed   <= n_closed;
            r_failed   <= n_failed;
        end
    end

    assign o_status             = r_o_status;
    assign o_granted_slot       = r_o_slot;
    assign o_granted_generation = r_o_gen;
    assign o_pool_is_failed     = r_failed;
    assign o_pool_is_open       = r_open;

endmodule

/* sv/frame_buffer_slot_manager.sv */
// ----------------------------------------------------------------------------
// frame_buffer_slot_manager
// Pool of buffer slots with state and generation tags, pool open, closed and
// failed flags, and an APB register for the number of slots in use.
//
//   channel    handshake              payload
//   request    i_valid / o_ready      i_op .. i_fence_failed_mask
//   result     o_valid / i_ready      o_status .. o_pool_is_open
//   config     psel/penable/pready    paddr, pwdata, prdata
//
// Each request is captured first, then evaluated through the slot table in
// a step that commits state and result together.
// A stalled result holds the evaluation cycle of the next request.
// Synchronous active-low reset: all slots free, generations zero, pool open,
// 8 slots in use.
// ----------------------------------------------------------------------------
module frame_buffer_slot_manager #(
    parameter int MAX_SLOT_COUNT = 8,
    parameter int GEN_BITS       = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  fbsm_pkg::t_op                  i_op,
    input  logic [fbsm_pkg::IDX_W-1:0]     i_slot_index,
    input  logic [fbsm_pkg::OUT_GEN_W-1:0] i_req_generation,
    input  logic                           i_sync_valid,
    input  logic [fbsm_pkg::FENCE_W-1:0]   i_fence_ready_mask,
    input  logic [fbsm_pkg::FENCE_W-1:0]   i_fence_failed_mask,
    output logic                           o_valid,
    input  logic                           i_ready,
    output fbsm_pkg::t_status              o_status,
    output logic [fbsm_pkg::IDX_W-1:0]     o_granted_slot,
    output logic [fbsm_pkg::OUT_GEN_W-1:0] o_granted_generation,
    output logic                           o_pool_is_failed,
    output logic                           o_pool_is_open,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import fbsm_pkg::*;

    localparam logic REG_ACTIVE_SLOTS = 1'b0;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    t_cmd             w_cmd;
    logic [CFG_W-1:0] r_active;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_SLOTS) ? 32'(r_active) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (psel && penable && pwrite && pready
                && (paddr[2] == REG_ACTIVE_SLOTS)) begin
            r_active <= pwdata[CFG_W-1:0];
        end
    end

    fbsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    fbsm_dp #(
        .MAX_SLOT_COUNT (MAX_SLOT_COUNT),
        .GEN_BITS       (GEN_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_active_slots       (r_active),
        .i_op                 (i_op),
        .i_slot_index         (i_slot_index),
        .i_req_generation     (i_req_generation),
        .i_sync_valid         (i_sync_valid),
        .i_fence_ready_mask   (i_fence_ready_mask),
        .i_fence_failed_mask  (i_fence_failed_mask),
        .o_status             (o_status),
        .o_granted_slot       (o_granted_slot),
        .o_granted_generation (o_granted_generation),
        .o_pool_is_failed     (o_pool_is_failed),
        .o_pool_is_open       (o_pool_is_open)
    );

endmodule
